// File: rtl/assert_macros.svh
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define SBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sbs_pkg.sv
// Package with the shared widths, action codes and status codes of the stack.
package sbs_pkg;

  localparam int DATA_W          = 32;
  localparam int ACTION_W        = 2;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SORT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// File: rtl/sbs_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
module sbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/sortable_bounded_stack.sv
// Push: result in the cycle after the transfer. Pop: the RAM read is registered, then S_POP registers the
// result; an empty stack answers in the cycle after the transfer. Sort of n entries: insertion sort through
// S_KEY, S_CMP and S_PUT, one RAM read and one RAM write per cycle while keys are shifted; n < 2 answers
// in the cycle after the transfer. One item at a time: the next input transfer comes the cycle after the result
// transfer. Reset (synchronous, active high) empties the stack; RAM contents are left as they are.
module sortable_bounded_stack #(
  parameter int STACK_DEPTH = sbs_pkg::STACK_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sbs_pkg::ACTION_W-1:0]         action,
  input  logic signed [sbs_pkg::DATA_W-1:0]    push_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sbs_pkg::DATA_W-1:0]    popped_value,
  output logic [sbs_pkg::STATUS_W-1:0]         status,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     entry_count
);
  import sbs_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_KEY  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     fill_count, fill_count_next;
  logic              out_valid_next;
  logic [DATA_W-1:0] popped, popped_next;
  logic [STATUS_W-1:0] status_q, status_next;
  logic [CW-1:0]     i_idx, i_idx_next;
  logic [CW-1:0]     j_idx, j_idx_next;
  logic [DATA_W-1:0] key, key_next;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  logic [CW-1:0]     cnt_dec;
  logic [CW-1:0]     i_inc;
  logic [CW-1:0]     i_dec;
  logic [CW-1:0]     j_dec;
  logic [CW-1:0]     j_dec2;
  logic              take;

  assign in_ready     = (state == S_IDLE) && !out_valid;
  assign take         = in_valid && in_ready;
  assign popped_value = popped;
  assign status       = status_q;
  assign entry_count  = fill_count;

  assign cnt_dec = fill_count - CW'(1);
  assign i_inc   = i_idx + CW'(1);
  assign i_dec   = i_idx - CW'(1);
  assign j_dec   = j_idx - CW'(1);
  assign j_dec2  = j_idx - CW'(2);

  // Entry store
  sbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequence actions and the insertion sort over the RAM
  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    out_valid_next  = out_valid && !out_ready;
    popped_next     = popped;
    status_next     = status_q;
    i_idx_next      = i_idx;
    j_idx_next      = j_idx;
    key_next        = key;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = key;
    rd_addr         = '0;

    unique case (state)
      S_IDLE: begin
        if (take) begin
          popped_next = '0;
          status_next = ST_OK;
          case (action)
            ACT_PUSH: begin
              out_valid_next = 1'b1;
              if (fill_count < DEPTH_C) begin
                wr_en           = 1'b1;
                wr_addr         = fill_count[AW-1:0];
                wr_data         = push_value;
                fill_count_next = fill_count + CW'(1);
              end else begin
                status_next = ST_FULL;
              end
            end
            ACT_POP: begin
              if (fill_count == '0) begin
                popped_next    = '1;
                status_next    = ST_EMPTY;
                out_valid_next = 1'b1;
              end else begin
                fill_count_next = cnt_dec;
                rd_addr         = cnt_dec[AW-1:0];
                state_next      = S_POP;
              end
            end
            ACT_SORT: begin
              if (fill_count <= CW'(1)) begin
                out_valid_next = 1'b1;
              end else begin
                i_idx_next = CW'(1);
                rd_addr    = AW'(1);
                state_next = S_KEY;
              end
            end
            default: begin
              out_valid_next = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        popped_next    = rd_data;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      S_KEY: begin
        // Hold the key, fetch its left neighbor
        key_next   = rd_data;
        j_idx_next = i_idx;
        rd_addr    = i_dec[AW-1:0];
        state_next = S_CMP;
      end
      S_CMP: begin
        if ($signed(rd_data) > $signed(key)) begin
          // Shift the larger entry up one slot
          wr_en      = 1'b1;
          wr_addr    = j_idx[AW-1:0];
          wr_data    = rd_data;
          j_idx_next = j_dec;
          if (j_idx == CW'(1)) begin
            state_next = S_PUT;
          end else begin
            rd_addr = j_dec2[AW-1:0];
          end
        end else begin
          // Drop the key into place and advance
          wr_en   = 1'b1;
          wr_addr = j_idx[AW-1:0];
          wr_data = key;
          if (i_inc < fill_count) begin
            i_idx_next = i_inc;
            rd_addr    = i_inc[AW-1:0];
            state_next = S_KEY;
          end else begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end
      end
      S_PUT: begin
        // Key is the smallest so far: store at the bottom
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = key;
        if (i_inc < fill_count) begin
          i_idx_next = i_inc;
          rd_addr    = i_inc[AW-1:0];
          state_next = S_KEY;
        end else begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload and sort working registers
  always_ff @(posedge clk) begin
    popped   <= popped_next;
    status_q <= status_next;
    i_idx    <= i_idx_next;
    j_idx    <= j_idx_next;
    key      <= key_next;
  end

  `include "assert_macros.svh"

  `SBS_ASSERT_ALWAYS(a_reset_idle, (rst |=> (state == S_IDLE && !out_valid)), "reset left the block busy")
  `SBS_ASSERT(a_count_bound, (fill_count <= DEPTH_C), "entry count above capacity")
  `SBS_ASSERT(a_push_grows, (take && action == ACT_PUSH && fill_count < DEPTH_C) |=> (fill_count == $past(fill_count) + CW'(1)), "push did not grow the stack")
  `SBS_ASSERT(a_sort_keeps_count, (state == S_CMP || state == S_KEY || state == S_PUT) |=> $stable(fill_count), "sort changed the entry count")
  `SBS_ASSERT(a_busy_no_result, (state != S_IDLE) |-> !in_ready, "input taken while busy")

endmodule
